// ===== sv/mlfq_task_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel feedback queue scheduler.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MLFQ_TASK_SCHEDULER_DEFINES_SVH
`define MLFQ_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define MLFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlfq_pkg.sv =====
// ---------------------------------------------------------------------------
// mlfq_pkg
// Shared codes and the result record of the feedback queue scheduler.
// ---------------------------------------------------------------------------
package mlfq_pkg;

    // Item kinds on the input side.
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_STEP   = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_RT      = 3'd2;
    localparam logic [2:0] ST_QUANTUM = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // Level numbering.
    localparam logic [1:0] LVL_RT   = 2'd0;
    localparam logic [1:0] LVL_LAST = 2'd3;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  run_task;
        logic [1:0]  run_level;
        logic [15:0] ran_ticks;
        logic        finished;
        logic        requeue_dropped;
        logic        all_empty;
        logic [31:0] time_now;
    } result_t;

endpackage

// ===== sv/mlfq_ram.sv =====
// ---------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/mlfq_front.sv =====
// ---------------------------------------------------------------------------
// mlfq_front
// Accepts input items, trims the id and saturates the required time to the
// stored widths, and holds the commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module mlfq_front import mlfq_pkg::*; #(
    parameter int ID_BITS     = 8,
    parameter int REMAIN_BITS = 16,
    parameter int CMD_W       = 3 + ID_BITS + REMAIN_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_action,
    input  logic [7:0]       in_task_id,
    input  logic [1:0]       in_priority_req,
    input  logic [15:0]      in_need_time,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output logic [CMD_W-1:0] cmd_data
);

    localparam logic [32:0] REM_MAX = (33'd1 << REMAIN_BITS) - 33'd1;

    logic [CMD_W-1:0] buf_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic [31:0]      id_wide;
    logic [31:0]      req_wide;
    logic [31:0]      req_sat;
    logic [CMD_W-1:0] cmd_in;
    logic             push;
    logic             pop;

    // Classify and fit the fields to the stored widths.
    always_comb
    begin
        id_wide  = {24'd0, in_task_id};
        req_wide = {16'd0, in_need_time};
        req_sat  = ({1'b0, req_wide} > REM_MAX) ? REM_MAX[31:0] : req_wide;
        cmd_in   = {req_sat[REMAIN_BITS-1:0], id_wide[ID_BITS-1:0],
                    in_priority_req, in_action};
    end

    // Queue control.
    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== sv/mlfq_back.sv =====
// ---------------------------------------------------------------------------
// mlfq_back
// Carries out arrive and step commands against the four level FIFOs held in
// one shared RAM, and holds each result in an output register.
// ---------------------------------------------------------------------------
module mlfq_back import mlfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8,
    parameter int REMAIN_BITS = 16,
    parameter int CMD_W       = 3 + ID_BITS + REMAIN_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = SLOT_BITS + 2;
    localparam int ADDR_W    = SLOT_BITS + 2;
    localparam int ENTRY_W   = ID_BITS + REMAIN_BITS;
    localparam int RAM_DEPTH = 4 * (1 << SLOT_BITS);

    localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(QUEUE_DEPTH - 1);

    // Sequencer states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [SLOT_BITS-1:0]   head_reg  [4];
    logic [SLOT_BITS-1:0]   head_next [4];
    logic [CNT_BITS-1:0]    count_reg  [4];
    logic [CNT_BITS-1:0]    count_next [4];
    logic [31:0]            time_reg;
    logic [31:0]            time_next;
    logic [1:0]             lvl_reg;
    logic [1:0]             lvl_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                res_reg;
    result_t                res_next;

    logic                   cmd_action;
    logic [1:0]             cmd_lvl;
    logic [ID_BITS-1:0]     cmd_id;
    logic [REMAIN_BITS-1:0] cmd_rem;
    logic [3:0]             nonempty;
    logic [1:0]             sel_lvl;
    logic [1:0]             demote_lvl;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0]     ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;
    logic [ID_BITS-1:0]     rd_id;
    logic [REMAIN_BITS-1:0] rd_rem;
    logic [31:0]            id_wide;
    logic [31:0]            rem_wide;

    // Slot just past the tail of a level, wrapped to the FIFO depth.
    function automatic logic [SLOT_BITS-1:0] tail_slot(
        input logic [SLOT_BITS-1:0] h,
        input logic [CNT_BITS-1:0]  c
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(c);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[SLOT_BITS-1:0];
    endfunction

    // Next head slot after a pop.
    function automatic logic [SLOT_BITS-1:0] head_inc(input logic [SLOT_BITS-1:0] h);
        return (h == LAST_SLOT) ? '0 : h + SLOT_BITS'(1);
    endfunction

    // Command fields.
    assign cmd_action = cmd_data[0];
    assign cmd_lvl    = cmd_data[2:1];
    assign cmd_id     = cmd_data[3 +: ID_BITS];
    assign cmd_rem    = cmd_data[3 + ID_BITS +: REMAIN_BITS];

    // Entry read back from the level FIFOs.
    assign rd_id    = ram_rd_data[ID_BITS-1:0];
    assign rd_rem   = ram_rd_data[ENTRY_W-1:ID_BITS];
    assign id_wide  = 32'(rd_id);
    assign rem_wide = 32'(rd_rem);

    // Level selection: the lowest-numbered nonempty level, real-time first.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            nonempty[k] = (count_reg[k] != '0);
        end
        if (nonempty[0])
        begin
            sel_lvl = 2'd0;
        end
        else if (nonempty[1])
        begin
            sel_lvl = 2'd1;
        end
        else if (nonempty[2])
        begin
            sel_lvl = 2'd2;
        end
        else
        begin
            sel_lvl = 2'd3;
        end
        demote_lvl = (lvl_reg == LVL_LAST) ? LVL_LAST : lvl_reg + 2'd1;
    end

    assign cmd_ready = (state_reg == S_IDLE) && (!out_valid_reg || res_ready);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        lvl_next       = lvl_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res_ready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd_action == ACT_ARRIVE)
                    begin
                        // Arrival: push at the tail unless the level is full.
                        res_next          = '0;
                        res_next.time_now = time_reg;
                        out_valid_next    = 1'b1;
                        if (count_reg[cmd_lvl] == FULL_CNT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.status     = ST_QUEUED;
                            ram_wr_en           = 1'b1;
                            ram_wr_addr         = {cmd_lvl,
                                tail_slot(head_reg[cmd_lvl], count_reg[cmd_lvl])};
                            ram_wr_data         = {cmd_rem, cmd_id};
                            count_next[cmd_lvl] = count_reg[cmd_lvl] + CNT_BITS'(1);
                        end
                    end
                    else if (nonempty == 4'b0000)
                    begin
                        // Idle step.
                        res_next           = '0;
                        res_next.status    = ST_IDLE;
                        res_next.all_empty = 1'b1;
                        res_next.time_now  = time_reg;
                        time_next          = time_reg + 32'd1;
                        out_valid_next     = 1'b1;
                    end
                    else
                    begin
                        // Pop the head of the chosen level and wait for the data.
                        ram_rd_en           = 1'b1;
                        ram_rd_addr         = {sel_lvl, head_reg[sel_lvl]};
                        head_next[sel_lvl]  = head_inc(head_reg[sel_lvl]);
                        count_next[sel_lvl] = count_reg[sel_lvl] - CNT_BITS'(1);
                        lvl_next            = sel_lvl;
                        state_next          = S_READ;
                    end
                end
            end
            S_READ:
            begin
                res_next          = '0;
                res_next.run_task = id_wide[7:0];
                res_next.time_now = time_reg;
                out_valid_next    = 1'b1;
                state_next        = S_IDLE;
                if (lvl_reg == LVL_RT)
                begin
                    // Real-time task runs to completion.
                    res_next.status    = ST_RT;
                    res_next.ran_ticks = rem_wide[15:0];
                    res_next.finished  = 1'b1;
                    time_next          = time_reg + rem_wide;
                end
                else
                begin
                    // One quantum, then finish or demote.
                    res_next.status    = ST_QUANTUM;
                    res_next.run_level = lvl_reg;
                    res_next.ran_ticks = 16'd1;
                    time_next          = time_reg + 32'd1;
                    if (rd_rem <= REMAIN_BITS'(1))
                    begin
                        res_next.finished = 1'b1;
                    end
                    else if (count_reg[demote_lvl] == FULL_CNT)
                    begin
                        res_next.requeue_dropped = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = {demote_lvl,
                            tail_slot(head_reg[demote_lvl], count_reg[demote_lvl])};
                        ram_wr_data = {rd_rem - REMAIN_BITS'(1), rd_id};
                        count_next[demote_lvl] = count_reg[demote_lvl] + CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                head_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Task storage for all four levels.
    mlfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_task_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== sv/mlfq_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// mlfq_task_scheduler
// Four-level feedback queue scheduler: a real-time level and three
// feedback levels that demote a task by one level after each quantum, down to the last.
// ---------------------------------------------------------------------------
// Usage:
// Items enter on s_axis; tuser selects arrival (0) or scheduling step (1),
// tdata carries the task id, its level and its required time. Every item
// gives exactly one result item on m_axis, with the status code on tuser.
// An accepted item is registered in the front queue. Arrivals and idle
// steps then register their result in the back end, and one such item
// completes per cycle while the result is taken and no run step is in
// progress. A step that runs a task reads the head from the task RAM
// in the S_IDLE state and writes a demoted entry back in S_READ; the
// back end takes no new command until this read-modify-write is done.
// The result register holds its item while m_axis_tready is low; the front
// queue keeps taking items until its two entries are full.
// Reset empties every level and clears the time; the task RAM needs no
// clearing, since only entries written by an arrival or demotion are read.
// ---------------------------------------------------------------------------
`include "mlfq_task_scheduler_defines.svh"

module mlfq_task_scheduler import mlfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8,
    parameter int REMAIN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // task_id[7:0], priority_req[9:8],
                                       // need_time[25:10], zero[31:26]
    input  logic        s_axis_tuser,  // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // run_task[7:0], run_level[9:8],
                                       // ran_ticks[25:10], finished[26],
                                       // requeue_dropped[27], all_empty[28],
                                       // time_now[60:29], zero[63:61]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    localparam int CMD_W = 3 + ID_BITS + REMAIN_BITS;

    logic             cmd_valid;
    logic             cmd_ready;
    logic [CMD_W-1:0] cmd_data;
    result_t          res;

    // Front end: accept and classify.
    mlfq_front #(
        .ID_BITS     (ID_BITS),
        .REMAIN_BITS (REMAIN_BITS),
        .CMD_W       (CMD_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_action        (s_axis_tuser),
        .in_task_id       (s_axis_tdata[7:0]),
        .in_priority_req  (s_axis_tdata[9:8]),
        .in_need_time     (s_axis_tdata[25:10]),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd_data         (cmd_data)
    );

    // Back end: run the level FIFOs.
    mlfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .REMAIN_BITS (REMAIN_BITS),
        .CMD_W       (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, res.time_now, res.all_empty, res.requeue_dropped,
                           res.finished, res.ran_ticks, res.run_level, res.run_task};
    assign m_axis_tuser = res.status;

    // An arrival result carries no run information.
    `MLFQ_ASSERT_NOW(a_arrive_clean,
        m_axis_tvalid && (res.status == ST_QUEUED || res.status == ST_FULL),
        res.run_task == 8'd0 && res.ran_ticks == 16'd0 && !res.finished
            && !res.requeue_dropped && !res.all_empty,
        "arrival result carries run fields")

    // Only an idle step reports that every level is empty.
    `MLFQ_ASSERT_NOW(a_idle_flag,
        m_axis_tvalid,
        res.all_empty == (res.status == ST_IDLE),
        "all_empty does not match idle status")

    // A drop happens only on an unfinished quantum run.
    `MLFQ_ASSERT_NOW(a_drop_quantum,
        m_axis_tvalid && res.requeue_dropped,
        res.status == ST_QUANTUM && !res.finished,
        "requeue drop outside an unfinished quantum run")

    // After a quantum run is taken, time moves by exactly one.
    `MLFQ_ASSERT_NEXT(a_quantum_time,
        m_axis_tvalid && m_axis_tready && res.status == ST_QUANTUM
            && !(s_axis_tvalid && s_axis_tready),
        !m_axis_tvalid || res.time_now == $past(res.time_now) + 32'd1,
        "time did not advance by one quantum")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the multilevel feedback queue scheduler
// Sends arrivals and scheduling steps on the input stream. A model of the
// four task levels and of the scheduler clock predicts every result item,
// and each one is checked field by field against the output stream. A short
// hand-written table comes first. Random episodes follow: mixed traffic,
// levels filled past their depth, and demotions into a full level. Both
// sides of the stream idle at random, differently in the first two phases.
// ---------------------------------------------------------------------------
module tb_top;
    import mlfq_pkg::*;

    localparam int LEVEL_DEPTH = 32;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Expected results that the directed table can state by itself.
    localparam result_t IDLE_AT_RESET = '{status: ST_IDLE, all_empty: 1'b1, default: '0};
    localparam result_t QUEUED_AT_ONE = '{status: ST_QUEUED, time_now: 32'd1, default: '0};
    localparam result_t LONG_RT_RUN = '{status: ST_RT, run_task: 8'hFF, run_level: LVL_RT,
                                        ran_ticks: 16'hFFFF, finished: 1'b1,
                                        time_now: 32'd1, default: '0};

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rem;
    } queued_task_t;

    typedef struct {
        logic        act;
        logic [7:0]  id;
        logic [1:0]  lvl;
        logic [15:0] need;
        bit          fixed;
        result_t     want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Scheduler model state.
    queued_task_t level_fifo[4][$];
    logic [31:0]  clock_now;

    result_t   pending_results[$];
    plan_row_t dir_plan[$];
    int        fail_count;
    int        src_idle_pct;
    int        sink_idle_pct;
    result_t   got_result;
    result_t   oldest_result;

    mlfq_task_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Apply one item to the model and return the result it should give.
    function automatic result_t schedule_one(input logic act, input logic [7:0] id,
                                             input logic [1:0] lvl, input logic [15:0] need);
        result_t      r;
        queued_task_t head;
        int           pick;
        int           next;
        r = '0;
        r.time_now = clock_now;
        pick = 0;
        if (act == ACT_ARRIVE)
        begin
            if (level_fifo[lvl].size() >= LEVEL_DEPTH)
                r.status = ST_FULL;
            else
            begin
                level_fifo[lvl].push_back('{id, need});
                r.status = ST_QUEUED;
            end
        end
        else if (level_fifo[LVL_RT].size() != 0)
        begin
            // The real-time head runs to completion in one go.
            head = level_fifo[LVL_RT].pop_front();
            r.status = ST_RT;
            r.run_task = head.id;
            r.ran_ticks = head.rem;
            r.finished = 1'b1;
            clock_now = clock_now + {16'd0, head.rem};
        end
        else
        begin
            for (int k = LVL_LAST; k >= 1; k--)
            begin
                if (level_fifo[k].size() != 0)
                    pick = k;
            end
            clock_now = clock_now + 32'd1;
            if (pick == 0)
            begin
                r.status = ST_IDLE;
                r.all_empty = 1'b1;
            end
            else
            begin
                // One quantum, then finish or move one level down.
                head = level_fifo[pick].pop_front();
                r.status = ST_QUANTUM;
                r.run_task = head.id;
                r.run_level = pick[1:0];
                r.ran_ticks = 16'd1;
                next = (pick < LVL_LAST) ? pick + 1 : LVL_LAST;
                if (head.rem <= 16'd1)
                    r.finished = 1'b1;
                else if (level_fifo[next].size() >= LEVEL_DEPTH)
                    r.requeue_dropped = 1'b1;
                else
                    level_fifo[next].push_back('{head.id, head.rem - 16'd1});
            end
        end
        return r;
    endfunction

    // Required time: mostly short, sometimes medium, rarely anything.
    function automatic logic [15:0] draw_need();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return 16'($urandom_range(0, 6));
        else if (roll < 95)
            return 16'($urandom_range(7, 300));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Drive one item, wait for its handshake and log its expected result.
    task automatic send_item(input logic act, input logic [7:0] id, input logic [1:0] lvl,
                             input logic [15:0] need, input bit fixed, input result_t want);
        result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, need, lvl, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = schedule_one(act, id, lvl, need);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Output side: random back-pressure, changed at the falling edge.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result = '{status: m_axis_tuser, run_task: m_axis_tdata[7:0],
                           run_level: m_axis_tdata[9:8], ran_ticks: m_axis_tdata[25:10],
                           finished: m_axis_tdata[26], requeue_dropped: m_axis_tdata[27],
                           all_empty: m_axis_tdata[28], time_now: m_axis_tdata[60:29]};
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation waiting");
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("status", 32'(oldest_result.status), 32'(got_result.status));
                check_field("run_task", 32'(oldest_result.run_task),
                            32'(got_result.run_task));
                check_field("run_level", 32'(oldest_result.run_level),
                            32'(got_result.run_level));
                check_field("ran_ticks", 32'(oldest_result.ran_ticks),
                            32'(got_result.ran_ticks));
                check_field("finished", 32'(oldest_result.finished),
                            32'(got_result.finished));
                check_field("requeue_dropped", 32'(oldest_result.requeue_dropped),
                            32'(got_result.requeue_dropped));
                check_field("all_empty", 32'(oldest_result.all_empty),
                            32'(got_result.all_empty));
                check_field("time_now", oldest_result.time_now, got_result.time_now);
                check_field("zero pad", 32'd0, {29'd0, m_axis_tdata[63:61]});
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("mlfq_task_scheduler: mismatch");
        $finish;
    end

    // Stimulus: directed table, then random episodes over three idle phases.
    initial
    begin : stimulus
        int rnd_count;
        int lvl;
        int tgt;
        int fill;
        int extra;
        int steps;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_ARRIVE;
        fail_count = 0;
        clock_now = '0;
        rnd_count = 0;
        src_idle_pct = 8;
        sink_idle_pct = 81;

        // Step on empty levels, extreme fields on every level, runs of
        // every kind, a zero-time real-time task, and round robin on the
        // last level.
        dir_plan.push_back('{ACT_STEP, 8'h00, 2'd0, 16'h0000, 1'b1, IDLE_AT_RESET});
        dir_plan.push_back('{ACT_ARRIVE, 8'hFF, LVL_RT, 16'hFFFF, 1'b1, QUEUED_AT_ONE});
        dir_plan.push_back('{ACT_ARRIVE, 8'h00, 2'd1, 16'h0000, 1'b1, QUEUED_AT_ONE});
        dir_plan.push_back('{ACT_ARRIVE, 8'hA5, 2'd2, 16'h0001, 1'b1, QUEUED_AT_ONE});
        dir_plan.push_back('{ACT_ARRIVE, 8'h5A, LVL_LAST, 16'h0002, 1'b1, QUEUED_AT_ONE});
        dir_plan.push_back('{ACT_ARRIVE, 8'h01, 2'd1, 16'h0003, 1'b1, QUEUED_AT_ONE});
        dir_plan.push_back('{ACT_STEP, 8'hFF, 2'd3, 16'hFFFF, 1'b1, LONG_RT_RUN});
        dir_plan.push_back('{ACT_ARRIVE, 8'h07, LVL_RT, 16'h0000, 1'b0, '0});
        for (int i = 0; i < 9; i++)
            dir_plan.push_back('{ACT_STEP, 8'h00, 2'd0, 16'h0000, 1'b0, '0});
        dir_plan.push_back('{ACT_ARRIVE, 8'h3C, 2'd2, 16'h5555, 1'b0, '0});
        dir_plan.push_back('{ACT_ARRIVE, 8'hC3, LVL_RT, 16'hAAAA, 1'b0, '0});
        dir_plan.push_back('{ACT_STEP, 8'h00, 2'd0, 16'h0000, 1'b0, '0});
        dir_plan.push_back('{ACT_STEP, 8'h00, 2'd0, 16'h0000, 1'b0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_plan[i])
            send_item(dir_plan[i].act, dir_plan[i].id, dir_plan[i].lvl, dir_plan[i].need,
                      dir_plan[i].fixed, dir_plan[i].want);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
            sink_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
            while (rnd_count < RANDOM_PER_PHASE * (phase + 1))
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        // Fill one level and push a few past its depth.
                        lvl = $urandom_range(0, 3);
                        fill = LEVEL_DEPTH - level_fifo[lvl].size() + $urandom_range(1, 3);
                        repeat (fill)
                            send_item(ACT_ARRIVE, 8'($urandom_range(0, 255)), 2'(lvl),
                                      draw_need(), 1'b0, '0);
                        rnd_count += fill;
                    end
                    2, 3:
                    begin
                        // Fill a feedback level, then demote tasks into it.
                        tgt = $urandom_range(2, 3);
                        fill = LEVEL_DEPTH - level_fifo[tgt].size();
                        repeat (fill)
                            send_item(ACT_ARRIVE, 8'($urandom_range(0, 255)), 2'(tgt),
                                      16'($urandom_range(2, 8)), 1'b0, '0);
                        extra = $urandom_range(2, 4);
                        repeat (extra)
                            send_item(ACT_ARRIVE, 8'($urandom_range(0, 255)), 2'(tgt - 1),
                                      16'($urandom_range(2, 6)), 1'b0, '0);
                        steps = level_fifo[LVL_RT].size() + $urandom_range(2, 6);
                        repeat (steps)
                            send_item(ACT_STEP, 8'($urandom_range(0, 255)),
                                      2'($urandom_range(0, 3)),
                                      16'($urandom_range(0, 65535)), 1'b0, '0);
                        rnd_count += fill + extra + steps;
                    end
                    default:
                    begin
                        // Mixed traffic, leaning toward steps so levels drain.
                        extra = $urandom_range(8, 20);
                        repeat (extra)
                        begin
                            if ($urandom_range(0, 99) < 60)
                                send_item(ACT_STEP, 8'($urandom_range(0, 255)),
                                          2'($urandom_range(0, 3)),
                                          16'($urandom_range(0, 65535)), 1'b0, '0);
                            else
                                send_item(ACT_ARRIVE, 8'($urandom_range(0, 255)),
                                          2'($urandom_range(0, 3)), draw_need(), 1'b0, '0);
                        end
                        rnd_count += extra;
                    end
                endcase
            end
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("mlfq_task_scheduler: match");
        else
            $display("mlfq_task_scheduler: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mlfq_pkg.sv
sv/mlfq_ram.sv
sv/mlfq_front.sv
sv/mlfq_back.sv
sv/mlfq_task_scheduler.sv
tb/tb_top.sv
